// File: hw/rtl/rrf_pkg.sv
// shared types, constants and codes of the range rule filter table
`default_nettype none

package rrf_pkg;

  // table geometry
  localparam int unsigned RULE_SLOTS = 16;
  localparam int unsigned IDX_W      = (RULE_SLOTS > 1) ? $clog2(RULE_SLOTS) : 1;
  localparam int unsigned CNT_W      = $clog2(RULE_SLOTS + 1);

  // one stored rule, last fields zero when the matching range flag is clear
  typedef struct packed {
    logic [31:0] ip_first;
    logic [31:0] ip_last;
    logic [15:0] port_first;
    logic [15:0] port_last;
    logic        ip_rng;
    logic        port_rng;
  } rule_t;

  // compare results of one slot against the current word
  typedef struct packed {
    logic equal;
    logic covers;
  } cmp_t;

  typedef enum logic [1:0] {
    CMD_ADD   = 2'd0,
    CMD_DEL   = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_INVALID  = 3'd1,
    ST_DELETED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_ACCEPTED = 3'd4,
    ST_REJECTED = 3'd5,
    ST_FULL     = 3'd6
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_e;

endpackage

`default_nettype wire

// File: hw/rtl/rrf_rule_mem.sv
// rule storage, one write port and one registered read port
`default_nettype none

module rrf_rule_mem (
  input  wire logic                       clk_i,
  input  wire logic                       we_i,
  input  wire logic [rrf_pkg::IDX_W-1:0]  waddr_i,
  input  wire rrf_pkg::rule_t             wdata_i,
  input  wire logic                       re_i,
  input  wire logic [rrf_pkg::IDX_W-1:0]  raddr_i,
  output rrf_pkg::rule_t                  rdata_o
);

  rrf_pkg::rule_t mem_q [rrf_pkg::RULE_SLOTS];
  rrf_pkg::rule_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // read port, registered output
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hw/rtl/rrf_slot_cmp.sv
// compares one read slot with the held rule and query
`default_nettype none

module rrf_slot_cmp (
  input  wire rrf_pkg::rule_t  entry_i,
  input  wire rrf_pkg::rule_t  key_i,
  input  wire logic [31:0]     query_ip_i,
  input  wire logic [15:0]     query_port_i,
  output rrf_pkg::cmp_t        cmp_o
);

  logic ip_cov;
  logic port_cov;

  // address and port coverage, exact hit or inside the ascending range
  assign ip_cov   = (query_ip_i == entry_i.ip_first) ||
                    (entry_i.ip_rng && (query_ip_i > entry_i.ip_first) &&
                     (query_ip_i <= entry_i.ip_last));
  assign port_cov = (query_port_i == entry_i.port_first) ||
                    (entry_i.port_rng && (query_port_i > entry_i.port_first) &&
                     (query_port_i <= entry_i.port_last));

  // full equality of all fields, last fields already normalized
  assign cmp_o.equal  = (entry_i == key_i);
  assign cmp_o.covers = ip_cov && port_cov;

endmodule

`default_nettype wire

// File: hw/rtl/range_rule_filter_table.sv
// Range rule filter table: firewall rules with address and port ranges.
// Input channel (in_valid_i / in_ready_o) takes one command word: add,
// delete or check. Output channel (out_valid_o / out_ready_i) returns one
// status word per command, in command order.
// The block works on one command at a time. It walks the rule slots in
// order, one slot per cycle, through a rule memory with one write port and
// one registered read port; valid bits live in flip-flops.
// How far the slot walk goes for each command:
//   add: up to the lowest free slot (all slots when full)
//   delete: all slots
//   check: up to the first covering slot, all slots on a miss
//   malformed range on add or delete, or unused command: no walk
// The status sits in an output register, so a new command is taken while
// a finished status still waits; a stalled receiver holds the next status
// in the block until the output register frees.
// Reset clears all valid bits (empty table) and the handshake state; rule
// contents are undefined until written, and a slot read before that is ignored.
`default_nettype none

module range_rule_filter_table (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  cmd_i,
  input  wire logic [31:0] rule_ip_first_i,
  input  wire logic [31:0] rule_ip_last_i,
  input  wire logic        rule_ip_is_range_i,
  input  wire logic [15:0] rule_port_first_i,
  input  wire logic [15:0] rule_port_last_i,
  input  wire logic        rule_port_is_range_i,
  input  wire logic [31:0] query_ip_i,
  input  wire logic [15:0] query_port_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o
);

  localparam logic [rrf_pkg::CNT_W-1:0] CntEnd = rrf_pkg::CNT_W'(rrf_pkg::RULE_SLOTS);
  localparam logic [rrf_pkg::IDX_W-1:0] IdxLast =
    rrf_pkg::IDX_W'(rrf_pkg::RULE_SLOTS - 1);

  rrf_pkg::state_e                state_q, state_d;
  rrf_pkg::cmd_e                  cmd_q, cmd_d;
  rrf_pkg::rule_t                 key_q, key_d;
  logic [31:0]                    qip_q, qip_d;
  logic [15:0]                    qport_q, qport_d;
  logic [rrf_pkg::CNT_W-1:0]      cnt_q, cnt_d;
  logic                           pipe_vld_q, pipe_vld_d;
  logic [rrf_pkg::IDX_W-1:0]      pipe_idx_q, pipe_idx_d;
  logic [rrf_pkg::RULE_SLOTS-1:0] valid_q, valid_d;
  logic                           found_q, found_d;
  rrf_pkg::status_e               res_q, res_d;
  logic                           out_valid_q, out_valid_d;
  rrf_pkg::status_e               status_q, status_d;

  rrf_pkg::rule_t                 in_rule;
  logic                           in_ok;
  logic [rrf_pkg::IDX_W-1:0]      cur_idx;
  logic                           mem_we;
  logic                           mem_re;
  rrf_pkg::rule_t                 rd_rule;
  rrf_pkg::cmp_t                  cmp;
  logic                           slot_hit;

  // normalize the incoming rule and check range ordering
  always_comb begin
    in_rule.ip_first   = rule_ip_first_i;
    in_rule.ip_last    = rule_ip_is_range_i ? rule_ip_last_i : 32'd0;
    in_rule.port_first = rule_port_first_i;
    in_rule.port_last  = rule_port_is_range_i ? rule_port_last_i : 16'd0;
    in_rule.ip_rng     = rule_ip_is_range_i;
    in_rule.port_rng   = rule_port_is_range_i;
    in_ok = (!rule_ip_is_range_i || (rule_ip_last_i > rule_ip_first_i)) &&
            (!rule_port_is_range_i || (rule_port_last_i > rule_port_first_i));
  end

  assign cur_idx = cnt_q[rrf_pkg::IDX_W-1:0];

  // rule storage
  rrf_rule_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (cur_idx),
    .wdata_i (key_q),
    .re_i    (mem_re),
    .raddr_i (cur_idx),
    .rdata_o (rd_rule)
  );

  // slot compare
  rrf_slot_cmp u_cmp (
    .entry_i      (rd_rule),
    .key_i        (key_q),
    .query_ip_i   (qip_q),
    .query_port_i (qport_q),
    .cmp_o        (cmp)
  );

  assign slot_hit = valid_q[pipe_idx_q];

  // command sequencer
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    key_d       = key_q;
    qip_d       = qip_q;
    qport_d     = qport_q;
    cnt_d       = cnt_q;
    pipe_vld_d  = 1'b0;
    pipe_idx_d  = cur_idx;
    valid_d     = valid_q;
    found_d     = found_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      rrf_pkg::S_IDLE: begin
        if (in_valid_i) begin
          key_d   = in_rule;
          qip_d   = query_ip_i;
          qport_d = query_port_i;
          cnt_d   = '0;
          found_d = 1'b0;
          case (cmd_i)
            rrf_pkg::CMD_ADD, rrf_pkg::CMD_DEL: begin
              cmd_d = rrf_pkg::cmd_e'(cmd_i);
              if (in_ok) begin
                state_d = rrf_pkg::S_SCAN;
              end else begin
                res_d   = rrf_pkg::ST_INVALID;
                state_d = rrf_pkg::S_DONE;
              end
            end
            rrf_pkg::CMD_CHECK: begin
              cmd_d   = rrf_pkg::CMD_CHECK;
              state_d = rrf_pkg::S_SCAN;
            end
            default: begin
              res_d   = rrf_pkg::ST_INVALID;
              state_d = rrf_pkg::S_DONE;
            end
          endcase
        end
      end

      rrf_pkg::S_SCAN: begin
        if (cmd_q == rrf_pkg::CMD_ADD) begin
          // lowest free slot takes the rule
          if (cnt_q == CntEnd) begin
            res_d   = rrf_pkg::ST_FULL;
            state_d = rrf_pkg::S_DONE;
          end else if (!valid_q[cur_idx]) begin
            mem_we           = 1'b1;
            valid_d[cur_idx] = 1'b1;
            res_d            = rrf_pkg::ST_ADDED;
            state_d          = rrf_pkg::S_DONE;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end else begin
          // issue the next slot read
          if (cnt_q != CntEnd) begin
            mem_re     = 1'b1;
            pipe_vld_d = 1'b1;
            cnt_d      = cnt_q + 1'b1;
          end
          // evaluate the slot read last cycle
          if (pipe_vld_q) begin
            if ((cmd_q == rrf_pkg::CMD_DEL) && slot_hit && cmp.equal) begin
              valid_d[pipe_idx_q] = 1'b0;
              found_d             = 1'b1;
            end
            if ((cmd_q == rrf_pkg::CMD_CHECK) && slot_hit && cmp.covers) begin
              res_d      = rrf_pkg::ST_ACCEPTED;
              state_d    = rrf_pkg::S_DONE;
              pipe_vld_d = 1'b0;
            end else if (pipe_idx_q == IdxLast) begin
              if (cmd_q == rrf_pkg::CMD_DEL) begin
                res_d = found_d ? rrf_pkg::ST_DELETED : rrf_pkg::ST_NOTFOUND;
              end else begin
                res_d = rrf_pkg::ST_REJECTED;
              end
              state_d    = rrf_pkg::S_DONE;
              pipe_vld_d = 1'b0;
            end
          end
        end
      end

      rrf_pkg::S_DONE: begin
        // hand the status over once the output register is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          status_d    = res_q;
          state_d     = rrf_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = rrf_pkg::S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rrf_pkg::S_IDLE;
      cnt_q       <= '0;
      pipe_vld_q  <= 1'b0;
      valid_q     <= '0;
      found_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pipe_vld_q  <= pipe_vld_d;
      valid_q     <= valid_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    qip_q      <= qip_d;
    qport_q    <= qport_d;
    pipe_idx_q <= pipe_idx_d;
    res_q      <= res_d;
    status_q   <= status_d;
  end

  assign in_ready_o  = (state_q == rrf_pkg::S_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;

`ifndef NO_ASSERTIONS
  // no slot read is in flight outside the scan
  a_no_read_outside_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != rrf_pkg::S_SCAN) |-> !pipe_vld_q)
    else $error("slot read pending outside scan");

  // the memory is written only by an add during the scan
  a_write_only_on_add: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ((state_q == rrf_pkg::S_SCAN) && (cmd_q == rrf_pkg::CMD_ADD)))
    else $error("rule memory written outside an add");

  // a check never changes the valid bits
  a_check_keeps_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == rrf_pkg::S_SCAN) && (cmd_q == rrf_pkg::CMD_CHECK)) |=>
      (valid_q == $past(valid_q)))
    else $error("valid bits changed by a check");

  // the slot counter never passes the table size
  a_cnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntEnd)
    else $error("slot counter beyond table size");

  // an add sets at most one valid bit
  a_add_one_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == rrf_pkg::S_SCAN) && (cmd_q == rrf_pkg::CMD_ADD)) |=>
      ($countones(valid_q) <= $countones($past(valid_q)) + 1))
    else $error("add set more than one slot");
`endif

endmodule

`default_nettype wire
